// ===== hdl/errt_pkg.sv =====
// Shared types and constants for the echo request round-trip tracker.
package errt_pkg;

	// Number of request slots, one cell each
	localparam int TABLE_SLOTS = 128;

	// Field widths
	localparam int SEQ_W   = 16;
	localparam int TIME_W  = 32;
	localparam int BYTES_W = 17;
	localparam int RTT_W   = 23;
	localparam int CNT_W   = 16;

	// Request kinds on req_type
	localparam logic REQ_SEND  = 1'b0;
	localparam logic REQ_REPLY = 1'b1;

	// ICMP type of an echo reply
	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

	// Shortest acceptable message after the IP header
	localparam logic signed [BYTES_W-1:0] MIN_MSG_BYTES = 17'sd8;

	// floor(x / 1000) for 32-bit x as (x * RTT_RECIP) >> RTT_SHIFT
	localparam int RTT_SHIFT = 41;
	localparam logic [TIME_W-1:0] RTT_RECIP = 32'd2199023256;

	// Result codes
	typedef enum logic [2:0] {
		ST_TRACKED   = 3'd0,
		ST_FULL      = 3'd1,
		ST_SEND_FAIL = 3'd2,
		ST_MATCHED   = 3'd3,
		ST_SHORT     = 3'd4,
		ST_NOT_OURS  = 3'd5,
		ST_UNKNOWN   = 3'd6
	} status_t;

	// What a token asks of the cells it passes
	typedef enum logic [1:0] {
		OP_PASS   = 2'd0,
		OP_SEND   = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	// One event traveling down the slot chain
	typedef struct packed {
		logic                      valid;
		op_t                       op;
		logic                      send_ok;
		status_t                   status;
		logic [SEQ_W-1:0]          seq;
		logic [TIME_W-1:0]         now_us;
		logic signed [BYTES_W-1:0] bytes;
		logic [CNT_W-1:0]          sent_total;
		logic                      hit;
		logic [TIME_W-1:0]         hit_time;
	} token_t;

endpackage

// ===== hdl/echo_request_rtt_tracker_unit.sv =====
// Top level of the echo request round-trip tracker: entry checks, sent count, slot chain.
//
//  channel  | signals                         | direction | transfer when
//  ---------+---------------------------------+-----------+-------------------------
//  cfg      | cfg_valid cfg_ready cfg_data     | in        | cfg_valid & cfg_ready
//  in       | in_valid in_ready + event fields | in        | in_valid & in_ready
//  out      | out_valid out_ready + results    | out       | out_valid & out_ready
//
// An event walks the chain of TABLE_SLOTS cells one cell per cycle while the chain
// does not stall, the input transfer loading the first, then passes through status
// resolve, the reciprocal multiply and the output register; one event is accepted
// per cycle unless the chain stalls.
// Reset clears all busy flags and both counters at once; no clearing pass.
// When the output holds an untaken result and another waits behind it, the whole
// chain stalls and in_ready drops.
module echo_request_rtt_tracker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [15:0]                          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [31:0]                          now_us,
	input  logic                                 send_ok,
	input  logic [7:0]                           msg_type,
	input  logic [15:0]                          msg_identifier,
	input  logic [15:0]                          msg_sequence,
	input  logic [3:0]                           ip_header_words,
	input  logic [15:0]                          packet_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           status,
	output logic [15:0]                          sequence_out,
	output logic [22:0]                          round_trip_ms,
	output logic signed [16:0]                   message_bytes,
	output logic [15:0]                          sent_total,
	output logic [15:0]                          received_total
);

	logic                                 adv;
	logic                                 in_xfer;
	logic [15:0]                          own_id_q;
	logic [errt_pkg::CNT_W-1:0]           sent_cnt_q;
	logic signed [errt_pkg::BYTES_W-1:0]  msg_len;
	errt_pkg::token_t                     tok_entry;
	errt_pkg::token_t                     tok [0:errt_pkg::TABLE_SLOTS];

	assign in_ready  = adv;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Identifier register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_id_q <= cfg_data;
		end
	end

	// Sent count advances on every successful send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_cnt_q <= '0;
		end else if (in_xfer && (req_type == errt_pkg::REQ_SEND) && send_ok) begin
			sent_cnt_q <= sent_cnt_q + errt_pkg::CNT_W'(1);
		end
	end

	// Message length without the IP header
	assign msg_len = signed'({1'b0, packet_length}) -
		signed'({11'b0, ip_header_words, 2'b00});

	// Build the token for the chain
	always_comb begin
		tok_entry          = '0;
		tok_entry.valid    = in_xfer;
		tok_entry.send_ok  = send_ok;
		tok_entry.now_us   = now_us;
		tok_entry.hit      = 1'b0;
		tok_entry.hit_time = '0;
		if (req_type == errt_pkg::REQ_SEND) begin
			tok_entry.op         = errt_pkg::OP_SEND;
			tok_entry.status     = errt_pkg::ST_TRACKED;
			tok_entry.seq        = sent_cnt_q;
			tok_entry.bytes      = '0;
			tok_entry.sent_total = sent_cnt_q +
				(send_ok ? errt_pkg::CNT_W'(1) : errt_pkg::CNT_W'(0));
		end else begin
			tok_entry.seq        = msg_sequence;
			tok_entry.bytes      = msg_len;
			tok_entry.sent_total = sent_cnt_q;
			if (msg_len < errt_pkg::MIN_MSG_BYTES) begin
				tok_entry.op     = errt_pkg::OP_PASS;
				tok_entry.status = errt_pkg::ST_SHORT;
			end else if ((msg_type != errt_pkg::ICMP_ECHO_REPLY) ||
				(msg_identifier != own_id_q)) begin
				tok_entry.op     = errt_pkg::OP_PASS;
				tok_entry.status = errt_pkg::ST_NOT_OURS;
			end else begin
				tok_entry.op     = errt_pkg::OP_SEARCH;
				tok_entry.status = errt_pkg::ST_UNKNOWN;
			end
		end
	end

	assign tok[0] = tok_entry;

	// Slot chain, lowest slot first
	for (genvar i = 0; i < errt_pkg::TABLE_SLOTS; i++) begin : g_slot
		errt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	errt_fin u_fin (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_in         (tok[errt_pkg::TABLE_SLOTS]),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.sequence_out   (sequence_out),
		.round_trip_ms  (round_trip_ms),
		.message_bytes  (message_bytes),
		.sent_total     (sent_total),
		.received_total (received_total)
	);

endmodule

// ===== hdl/errt_cell.sv =====
// One slot of the request table; inspects and forwards one token per cycle while adv is high.
module errt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  errt_pkg::token_t tok_in,
	output errt_pkg::token_t tok_out
);

	logic                         busy_q;
	logic [errt_pkg::SEQ_W-1:0]   seq_q;
	logic [errt_pkg::TIME_W-1:0]  time_q;
	errt_pkg::token_t             tok_q;
	errt_pkg::token_t             tok_nxt;
	logic                         claim;
	logic                         match;

	// First free slot takes a send, first busy slot with the sequence takes a reply
	assign claim = tok_in.valid && !tok_in.hit && (tok_in.op == errt_pkg::OP_SEND) && !busy_q;
	assign match = tok_in.valid && !tok_in.hit && (tok_in.op == errt_pkg::OP_SEARCH) &&
		busy_q && (seq_q == tok_in.seq);

	// Token as handed to the next cell
	always_comb begin
		tok_nxt     = tok_in;
		tok_nxt.hit = tok_in.hit | claim | match;
		if (match) begin
			tok_nxt.hit_time = time_q;
		end
	end

	// Busy flag and token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok_q  <= '0;
		end else if (adv) begin
			if (claim) begin
				busy_q <= 1'b1;
			end else if (match) begin
				busy_q <= 1'b0;
			end
			tok_q <= tok_nxt;
		end
	end

	// Slot payload, written on claim only
	always_ff @(posedge clk) begin
		if (adv && claim) begin
			seq_q  <= tok_in.seq;
			time_q <= tok_in.now_us;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hdl/errt_fin.sv =====
// Chain exit: final status, received count, round-trip divide and output register.
module errt_fin (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  errt_pkg::token_t                     tok_in,
	output logic                                 adv,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           status,
	output logic [errt_pkg::SEQ_W-1:0]           sequence_out,
	output logic [errt_pkg::RTT_W-1:0]           round_trip_ms,
	output logic signed [errt_pkg::BYTES_W-1:0]  message_bytes,
	output logic [errt_pkg::CNT_W-1:0]           sent_total,
	output logic [errt_pkg::CNT_W-1:0]           received_total
);

	errt_pkg::status_t                   status_c;
	logic [errt_pkg::CNT_W-1:0]          recv_cnt_q;
	logic [errt_pkg::CNT_W-1:0]          recv_next;
	logic [2*errt_pkg::TIME_W-1:0]       product;

	logic                                valid_s1;
	errt_pkg::status_t                   status_s1;
	logic [errt_pkg::SEQ_W-1:0]          seq_s1;
	logic [errt_pkg::TIME_W-1:0]         diff_s1;
	logic signed [errt_pkg::BYTES_W-1:0] bytes_s1;
	logic [errt_pkg::CNT_W-1:0]          sent_s1;
	logic [errt_pkg::CNT_W-1:0]          recv_s1;

	logic                                valid_s2;
	errt_pkg::status_t                   status_s2;
	logic [errt_pkg::SEQ_W-1:0]          seq_s2;
	logic [2*errt_pkg::TIME_W-1:0]       product_s2;
	logic signed [errt_pkg::BYTES_W-1:0] bytes_s2;
	logic [errt_pkg::CNT_W-1:0]          sent_s2;
	logic [errt_pkg::CNT_W-1:0]          recv_s2;

	logic                                out_valid_q;
	errt_pkg::status_t                   status_q;
	logic [errt_pkg::SEQ_W-1:0]          seq_q;
	logic [errt_pkg::RTT_W-1:0]          rtt_q;
	logic signed [errt_pkg::BYTES_W-1:0] bytes_q;
	logic [errt_pkg::CNT_W-1:0]          sent_q;
	logic [errt_pkg::CNT_W-1:0]          recv_q;

	// Whole pipeline holds only while a finished result waits behind a full output
	assign adv = !(out_valid_q && !out_ready && valid_s2);

	// Resolve status from what the chain found
	always_comb begin
		case (tok_in.op)
			errt_pkg::OP_SEND: begin
				if (!tok_in.send_ok) begin
					status_c = errt_pkg::ST_SEND_FAIL;
				end else if (tok_in.hit) begin
					status_c = errt_pkg::ST_TRACKED;
				end else begin
					status_c = errt_pkg::ST_FULL;
				end
			end
			errt_pkg::OP_SEARCH: begin
				status_c = tok_in.hit ? errt_pkg::ST_MATCHED : errt_pkg::ST_UNKNOWN;
			end
			default: status_c = tok_in.status;
		endcase
	end

	assign recv_next = recv_cnt_q + ((tok_in.valid && status_c == errt_pkg::ST_MATCHED) ?
		errt_pkg::CNT_W'(1) : errt_pkg::CNT_W'(0));

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			recv_cnt_q <= '0;
		end else if (adv) begin
			valid_s1   <= tok_in.valid;
			recv_cnt_q <= recv_next;
		end
	end

	// Stage 1 payload: elapsed microseconds, modulo 2^32
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= status_c;
			seq_s1    <= tok_in.seq;
			diff_s1   <= tok_in.now_us - tok_in.hit_time;
			bytes_s1  <= tok_in.bytes;
			sent_s1   <= tok_in.sent_total;
			recv_s1   <= recv_next;
		end
	end

	// Stage 2: reciprocal multiply for the divide by 1000
	assign product = diff_s1 * errt_pkg::RTT_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= status_s1;
			seq_s2     <= seq_s1;
			product_s2 <= product;
			bytes_s2   <= bytes_s1;
			sent_s2    <= sent_s1;
			recv_s2    <= recv_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			status_q <= status_s2;
			seq_q    <= seq_s2;
			rtt_q    <= (status_s2 == errt_pkg::ST_MATCHED) ?
				product_s2[errt_pkg::RTT_SHIFT +: errt_pkg::RTT_W] : '0;
			bytes_q  <= bytes_s2;
			sent_q   <= sent_s2;
			recv_q   <= recv_s2;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign sequence_out   = seq_q;
	assign round_trip_ms  = rtt_q;
	assign message_bytes  = bytes_q;
	assign sent_total     = sent_q;
	assign received_total = recv_q;

	// A round-trip time is only reported for a matched reply
	a_rtt_only_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != errt_pkg::ST_MATCHED) |-> (rtt_q == '0))
		else $error("round-trip time set on a result that is not a match");

	// Received count moves by at most one per cycle
	a_recv_step: assert property (@(posedge clk) disable iff (!arst_n)
		(recv_cnt_q != $past(recv_cnt_q)) |-> (recv_cnt_q == $past(recv_cnt_q) + 16'd1))
		else $error("received count jumped");

	// A held result keeps the product behind it frozen
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && valid_s2 |=> $stable(product_s2) && valid_s2)
		else $error("stage 2 moved during a stall");

endmodule
